FILE: rtl/dct_idct_8x8_block_core_macros.svh
// assertion macros for the 8x8 dct/idct block core
// used by the top level only, needs clk and rst_n in scope
`ifndef DCT_IDCT_8X8_BLOCK_CORE_MACROS_SVH
`define DCT_IDCT_8X8_BLOCK_CORE_MACROS_SVH

// same-cycle implication
`define DIB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dib_pkg.sv
// shared types, constants and the cosine coefficient function
// for the 8x8 dct/idct block; no dependencies
package dib_pkg;

  localparam int COS_FRAC    = 30;
  localparam int TRANS_EXTRA = 6;
  localparam int TRANS_FRAC  = 4;

  // cos(m*pi/16), m = 0..8, 30 fractional bits
  localparam logic [30:0] COS_TAB [0:8] = '{
    31'd1073741824, 31'd1053110176, 31'd992008094, 31'd892783698, 31'd759250125,
    31'd596538995, 31'd410903207, 31'd209476638, 31'd0
  };

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_ROW,
    ST_ROW_DRAIN,
    ST_COL,
    ST_COL_DRAIN,
    ST_EMIT
  } dib_state_t;

  typedef struct packed {
    logic       in_wr;
    logic [5:0] in_addr;
    logic       issue;
    logic       pass_col;
    logic       first;
    logic       last;
    logic [5:0] idx;
    logic [2:0] ci;
    logic [2:0] cj;
    logic [5:0] rd_addr;
    logic       emit_rd;
    logic       inv;
  } dib_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dib_status_t;

  // c(k) * cos((2n+1) k pi/16), magnitude rounded to cf fractional bits
  function automatic logic signed [31:0] coef_val(input logic [2:0] k, input logic [2:0] n,
                                                  input int cf);
    logic [4:0]  t;
    logic [4:0]  m;
    logic        neg;
    logic [30:0] v;
    logic [31:0] r;
    t   = {1'b0, n, 1'b0} + 5'd1;
    m   = 5'(t * {2'b00, k});
    neg = 1'b0;
    if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
    if (m > 5'd8) begin
      m   = 5'd16 - m;
      neg = 1'b1;
    end
    v = (k == 3'd0) ? COS_TAB[4] : COS_TAB[m[3:0]];
    r = ({1'b0, v} + (32'd1 << (COS_FRAC - 1 - cf))) >> (COS_FRAC - cf);
    return neg ? $signed(-r) : $signed(r);
  endfunction

endpackage

FILE: rtl/dib_ctrl.sv
// sequencer for the 8x8 dct/idct block: input collection, row and
// column passes, result emission; uses dib_pkg
module dib_ctrl import dib_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  dib_status_t status,
  output dib_cmd_t    cmd
);

  dib_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [2:0] j_r, j_nxt;
  logic       inv_r, inv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= '0;
      j_r     <= '0;
      inv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
      inv_r   <= inv_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    inv_nxt   = inv_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_valid) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_nxt = ST_ROW;
            inv_nxt   = mode;
          end
        end
      end
      ST_ROW, ST_COL: begin
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd7) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_nxt = (state_r == ST_ROW) ? ST_ROW_DRAIN : ST_COL_DRAIN;
        end
      end
      ST_ROW_DRAIN: begin
        if (!status.busy) state_nxt = ST_COL;
      end
      ST_COL_DRAIN: begin
        if (!status.busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // commands
  always_comb begin
    in_stall     = (state_r != ST_COLLECT);
    cmd          = '0;
    cmd.inv      = inv_r;
    cmd.in_addr  = cnt_r;
    cmd.idx      = cnt_r;
    cmd.cj       = j_r;
    cmd.first    = (j_r == 3'd0);
    cmd.last     = (j_r == 3'd7);
    case (state_r)
      ST_COLLECT: cmd.in_wr = in_valid;
      ST_ROW: begin
        cmd.issue   = 1'b1;
        cmd.ci      = cnt_r[2:0];
        cmd.rd_addr = {cnt_r[5:3], j_r};
      end
      ST_COL: begin
        cmd.issue    = 1'b1;
        cmd.pass_col = 1'b1;
        cmd.ci       = cnt_r[5:3];
        cmd.rd_addr  = {j_r, cnt_r[2:0]};
      end
      ST_EMIT: begin
        cmd.emit_rd = status.out_free;
        cmd.rd_addr = cnt_r;
      end
      default: cmd.issue = 1'b0;
    endcase
  end

endmodule

FILE: rtl/dib_dp.sv
// datapath for the 8x8 dct/idct block: block and transpose memories,
// one multiply-accumulate pipeline, rounding, output register; uses dib_pkg
module dib_dp import dib_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int DATA_BITS      = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dib_cmd_t                    cmd,
  output dib_status_t                 status,
  input  logic        [DATA_BITS-1:0] in_sample_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic        [DATA_BITS-1:0] out_result_value,
  output logic                        out_last_of_block
);

  localparam int TB    = DATA_BITS + TRANS_EXTRA;
  localparam int CW    = COEF_FRAC_BITS + 1;
  localparam int PW    = TB + CW;
  localparam int AW    = PW + 3;
  localparam int S_ROW = COEF_FRAC_BITS + 1 - TRANS_FRAC;
  localparam int S_COL = COEF_FRAC_BITS + 1 + TRANS_FRAC;
  localparam logic [AW:0] ROW_POS = (AW+1)'((1 << (TB-1)) - 1);
  localparam logic [AW:0] ROW_NEG = (AW+1)'(1 << (TB-1));
  localparam logic [AW:0] COL_POS = (AW+1)'((1 << (DATA_BITS-1)) - 1);
  localparam logic [AW:0] COL_NEG = (AW+1)'(1 << (DATA_BITS-1));

  logic signed [DATA_BITS-1:0] mem_a [0:63];
  logic signed [TB-1:0]        mem_t [0:63];

  logic signed [DATA_BITS-1:0] a_rd_r;
  logic signed [TB-1:0]        t_rd_r;
  logic signed [CW-1:0]        coef1_r;
  logic                        v1_r, first1_r, last1_r, col1_r;
  logic [5:0]                  idx1_r;
  logic signed [PW-1:0]        prod_r;
  logic                        v2_r, first2_r, last2_r, col2_r;
  logic [5:0]                  idx2_r;
  logic signed [AW-1:0]        acc_r;
  logic                        fin_r, col3_r;
  logic [5:0]                  idx3_r;
  logic                        emit_pend_r, emit_last_r;
  logic                        out_valid_r, out_last_r;
  logic [DATA_BITS-1:0]        out_value_r;

  logic signed [31:0]          coef_full;
  logic signed [TB-1:0]        op;
  logic signed [AW:0]          acc_x;
  logic [AW:0]                 mag, rnd_row, rnd_col, c_row, c_col;
  logic                        neg;
  logic signed [TB-1:0]        row_res;
  logic signed [DATA_BITS-1:0] col_res;
  logic                        a_we;
  logic [5:0]                  a_waddr;
  logic signed [DATA_BITS-1:0] a_wdata;

  // coefficient of the transform matrix, output index i, input index j
  always_comb begin
    if (cmd.inv) coef_full = coef_val(cmd.cj, cmd.ci, COEF_FRAC_BITS);
    else         coef_full = coef_val(cmd.ci, cmd.cj, COEF_FRAC_BITS);
  end

  assign op = col1_r ? t_rd_r : TB'(a_rd_r);

  // round half away from zero, then saturate
  always_comb begin
    acc_x   = (AW+1)'(acc_r);
    neg     = acc_r[AW-1];
    mag     = neg ? $unsigned(-acc_x) : $unsigned(acc_x);
    rnd_row = (mag + ((AW+1)'(1) << (S_ROW-1))) >> S_ROW;
    rnd_col = (mag + ((AW+1)'(1) << (S_COL-1))) >> S_COL;
    if (neg) begin
      c_row = (rnd_row > ROW_NEG) ? ROW_NEG : rnd_row;
      c_col = (rnd_col > COL_NEG) ? COL_NEG : rnd_col;
    end else begin
      c_row = (rnd_row > ROW_POS) ? ROW_POS : rnd_row;
      c_col = (rnd_col > COL_POS) ? COL_POS : rnd_col;
    end
    row_res = TB'(neg ? -c_row : c_row);
    col_res = DATA_BITS'(neg ? -c_col : c_col);
  end

  assign a_we    = cmd.in_wr | (fin_r & col3_r);
  assign a_waddr = cmd.in_wr ? cmd.in_addr : idx3_r;
  assign a_wdata = cmd.in_wr ? $signed(in_sample_value) : col_res;

  // memories
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (fin_r && !col3_r) mem_t[idx3_r] <= row_res;
    a_rd_r <= mem_a[cmd.rd_addr];
    t_rd_r <= mem_t[cmd.rd_addr];
  end

  // mac pipeline payload
  always_ff @(posedge clk) begin
    coef1_r  <= coef_full[CW-1:0];
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    col1_r   <= cmd.pass_col;
    idx1_r   <= cmd.idx;
    prod_r   <= op * coef1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    col2_r   <= col1_r;
    idx2_r   <= idx1_r;
    if (v2_r) acc_r <= first2_r ? AW'(prod_r) : acc_r + AW'(prod_r);
    col3_r   <= col2_r;
    idx3_r   <= idx2_r;
    emit_last_r <= (cmd.rd_addr == 6'd63);
    if (emit_pend_r) begin
      out_value_r <= a_rd_r;
      out_last_r  <= emit_last_r;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      fin_r       <= 1'b0;
      emit_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      fin_r       <= v2_r & last2_r;
      emit_pend_r <= cmd.emit_rd;
      if (emit_pend_r)        out_valid_r <= 1'b1;
      else if (!out_stall)    out_valid_r <= 1'b0;
    end
  end

  assign status.busy     = v1_r | v2_r | fin_r;
  assign status.out_free = !out_valid_r && !emit_pend_r;

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_last_of_block = out_last_r;

endmodule

FILE: rtl/dct_idct_8x8_block_core.sv
// 8x8 block dct / idct core, top level with the register port
// depends on dib_pkg, dib_ctrl, dib_dp and dct_idct_8x8_block_core_macros.svh
//
// usage
// - input channel in_valid/in_stall/in_sample_value: 64 signed elements of
//   one 8x8 block in raster order, one request per cycle while collecting
// - register 0 at byte address 0 holds inverse_mode (0 forward, 1 inverse);
//   it is sampled when the 64th element of a block is taken
// - result channel out_valid/out_stall: 64 results in raster order,
//   out_last_of_block marks the 64th
// - one multiply-accumulate unit does both passes: the row pass, then the
//   column pass, each followed by a drain of its pipeline
// - results leave one at a time through a registered memory read and the
//   output register; a new read is issued only once the output register is empty
// - in_stall is high from the 64th element until the last result read is
//   issued; a stalled receiver just holds the output register and the
//   sequencer waits
// - synchronous active-low reset clears the sequencer, mode and valid flags;
//   the block memories hold no reset value and are always written before use
`include "dct_idct_8x8_block_core_macros.svh"

module dct_idct_8x8_block_core import dib_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int DATA_BITS      = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_BITS-1:0] in_sample_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_BITS-1:0] out_result_value,
  output logic                 out_last_of_block,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic        mode_r;
  dib_cmd_t    cmd;
  dib_status_t status;

  // only register 0 exists; bit 2 of the address picks beyond it
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode_r <= pwdata[0];
    end
  end

  // sequencer
  dib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode_r),
    .status   (status),
    .cmd      (cmd)
  );

  // memories, mac pipeline and output register
  dib_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .DATA_BITS      (DATA_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_last_of_block (out_last_of_block)
  );

  // a request is never taken while the mac pipeline still runs
  `DIB_ASSERT_NOW(a_no_input_while_busy, !in_stall, !status.busy, "input taken while busy")
  // a result read is issued only into a free output slot
  `DIB_ASSERT_NOW(a_emit_into_free, cmd.emit_rd, status.out_free, "emit into full output")
  // nothing follows the last result of a block until the next block is done
  `DIB_ASSERT_NEXT(a_last_ends_block, out_valid && out_last_of_block && !out_stall,
                   !out_valid, "result after last of block")

endmodule
